@@ rtl/assert_macros.svh @@
// assertion macros included by the serial frame encoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/sfe_pkg.sv @@
// types, constants and crc function for the serial frame encoder
package sfe_pkg;

  localparam logic [12:0] MAX_PAYLOAD = 13'd4096;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_MSB     = 16'h8000;
  localparam logic [15:0] SEQ_MAX     = 16'hFFFF;
  localparam logic [8:0]  LEN_OFFSET_RESET = 9'd6;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam logic [2:0] CFG_HEAD_FIRST    = 3'd0;
  localparam logic [2:0] CFG_HEAD_SECOND   = 3'd1;
  localparam logic [2:0] CFG_TAIL_FIRST    = 3'd2;
  localparam logic [2:0] CFG_TAIL_SECOND   = 3'd3;
  localparam logic [2:0] CFG_LENGTH_OFFSET = 3'd4;

  // which byte of the frame the current item emits next
  typedef enum logic [3:0] {
    SLOT_HEAD_FIRST,
    SLOT_HEAD_SECOND,
    SLOT_LEN_HI,
    SLOT_LEN_LO,
    SLOT_SEQ_HI,
    SLOT_SEQ_LO,
    SLOT_CMD_HI,
    SLOT_CMD_LO,
    SLOT_CRC_HI,
    SLOT_CRC_LO,
    SLOT_TAIL_FIRST,
    SLOT_TAIL_SECOND,
    SLOT_PAYLOAD
  } slot_t;

  // crc-16, msb first, one byte
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/serial_frame_encoder_crc16.sv @@
// serial command frame builder with crc-16 trailer
//
// Input channel (in_valid / in_stall): in_op 0 starts a frame with in_command and
// in_payload_len, in_op 1 delivers in_payload_byte. Output channel (out_valid /
// out_stall) carries one frame byte per transaction with run_last and frame_end.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (head bytes,
// tail bytes, signed length offset); write only while the block is idle.
// An accepted item sits in the input register and, unless the output stalls,
// emits one byte per cycle into the output register, which offers its bytes.
// A start emits 8 bytes (12 with an empty payload), a payload byte one byte (5
// when it is the last one and the trailer follows); a payload byte outside a frame
// is dropped, emitting nothing. The next item is taken in the cycle its
// predecessor emits its last byte, so a payload stream runs at one byte per cycle
// with no output stall. The byte-wise crc update sits between the two registers.
// Reset clears the sequence number, closes any frame and restores the register
// defaults. A stall on the output holds the output register and, once the input
// register item has bytes left, stalls the input as well.
module serial_frame_encoder_crc16
  import sfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_command,
  input  logic [12:0] in_payload_len,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_frame_end,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

`include "assert_macros.svh"

  // configuration
  logic [7:0] head_first_r, head_second_r, tail_first_r, tail_second_r;
  logic [8:0] length_offset_r;

  // input register
  logic        cur_valid_r;
  logic        cur_op_r;
  logic [15:0] cur_cmd_r;
  logic [12:0] cur_len_r;
  logic [7:0]  cur_byte_r;
  slot_t       slot_r, slot_nxt;

  // frame state
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [12:0] remain_r, remain_nxt;
  logic        open_r, open_nxt;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_run_last_r;
  logic       out_frame_end_r;

  logic        out_load, drop, adv, emit_last, cur_done, accept;
  logic        crc_en;
  logic [7:0]  emit_byte;
  logic [15:0] len_field;
  logic [12:0] len_sat;

  assign out_load = !out_valid_r || !out_stall;
  assign drop     = cur_valid_r && (cur_op_r == OP_PAYLOAD) && !open_r;
  assign adv      = cur_valid_r && !drop && out_load;
  assign cur_done = drop || (adv && emit_last);
  assign in_stall = cur_valid_r && !cur_done;
  assign accept   = in_valid && !in_stall;

  assign len_sat   = (in_payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : in_payload_len;
  assign len_field = {3'b000, cur_len_r} + {{7{length_offset_r[8]}}, length_offset_r};

  // byte select for the current slot
  always_comb begin
    emit_byte = 8'h00;
    emit_last = 1'b0;
    crc_en    = 1'b0;
    unique case (slot_r)
      SLOT_HEAD_FIRST:  emit_byte = head_first_r;
      SLOT_HEAD_SECOND: emit_byte = head_second_r;
      SLOT_LEN_HI: begin
        emit_byte = len_field[15:8];
        crc_en    = 1'b1;
      end
      SLOT_LEN_LO: begin
        emit_byte = len_field[7:0];
        crc_en    = 1'b1;
      end
      SLOT_SEQ_HI: begin
        emit_byte = seq_r[15:8];
        crc_en    = 1'b1;
      end
      SLOT_SEQ_LO: begin
        emit_byte = seq_r[7:0];
        crc_en    = 1'b1;
      end
      SLOT_CMD_HI: begin
        emit_byte = cur_cmd_r[15:8];
        crc_en    = 1'b1;
      end
      SLOT_CMD_LO: begin
        emit_byte = cur_cmd_r[7:0];
        crc_en    = 1'b1;
        emit_last = (cur_len_r != 13'd0);
      end
      SLOT_CRC_HI:     emit_byte = crc_r[15:8];
      SLOT_CRC_LO:     emit_byte = crc_r[7:0];
      SLOT_TAIL_FIRST: emit_byte = tail_first_r;
      SLOT_TAIL_SECOND: begin
        emit_byte = tail_second_r;
        emit_last = 1'b1;
      end
      SLOT_PAYLOAD: begin
        emit_byte = cur_byte_r;
        crc_en    = 1'b1;
        emit_last = (remain_r != 13'd1);
      end
      default: ;
    endcase
  end

  // next slot and frame state
  always_comb begin
    slot_nxt   = slot_r;
    seq_nxt    = seq_r;
    crc_nxt    = crc_r;
    remain_nxt = remain_r;
    open_nxt   = open_r;
    if (adv) begin
      if (crc_en) begin
        crc_nxt = crc16_feed(crc_r, emit_byte);
      end
      unique case (slot_r)
        SLOT_HEAD_FIRST: begin
          slot_nxt   = SLOT_HEAD_SECOND;
          seq_nxt    = (seq_r == SEQ_MAX) ? 16'd1 : seq_r + 16'd1;
          crc_nxt    = CRC_INIT;
          remain_nxt = cur_len_r;
          open_nxt   = (cur_len_r != 13'd0);
        end
        SLOT_HEAD_SECOND: slot_nxt = SLOT_LEN_HI;
        SLOT_LEN_HI:      slot_nxt = SLOT_LEN_LO;
        SLOT_LEN_LO:      slot_nxt = SLOT_SEQ_HI;
        SLOT_SEQ_HI:      slot_nxt = SLOT_SEQ_LO;
        SLOT_SEQ_LO:      slot_nxt = SLOT_CMD_HI;
        SLOT_CMD_HI:      slot_nxt = SLOT_CMD_LO;
        SLOT_CMD_LO:      slot_nxt = SLOT_CRC_HI;
        SLOT_CRC_HI:      slot_nxt = SLOT_CRC_LO;
        SLOT_CRC_LO:      slot_nxt = SLOT_TAIL_FIRST;
        SLOT_TAIL_FIRST:  slot_nxt = SLOT_TAIL_SECOND;
        SLOT_TAIL_SECOND: begin
          open_nxt   = 1'b0;
          remain_nxt = 13'd0;
        end
        SLOT_PAYLOAD: begin
          slot_nxt   = SLOT_CRC_HI;
          remain_nxt = remain_r - 13'd1;
        end
        default: ;
      endcase
    end
    // a fresh item restarts at its first slot
    if (accept) begin
      slot_nxt = (in_op == OP_PAYLOAD) ? SLOT_PAYLOAD : SLOT_HEAD_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_first_r    <= 8'h00;
      head_second_r   <= 8'h00;
      tail_first_r    <= 8'h00;
      tail_second_r   <= 8'h00;
      length_offset_r <= LEN_OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAD_FIRST:    head_first_r    <= cfg_wdata[7:0];
        CFG_HEAD_SECOND:   head_second_r   <= cfg_wdata[7:0];
        CFG_TAIL_FIRST:    tail_first_r    <= cfg_wdata[7:0];
        CFG_TAIL_SECOND:   tail_second_r   <= cfg_wdata[7:0];
        CFG_LENGTH_OFFSET: length_offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      slot_r      <= SLOT_HEAD_FIRST;
      seq_r       <= 16'h0000;
      crc_r       <= CRC_INIT;
      remain_r    <= 13'd0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= accept || (cur_valid_r && !cur_done);
      slot_r      <= slot_nxt;
      seq_r       <= seq_nxt;
      crc_r       <= crc_nxt;
      remain_r    <= remain_nxt;
      open_r      <= open_nxt;
      if (out_load) begin
        out_valid_r <= adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op_r   <= in_op;
      cur_cmd_r  <= in_command;
      cur_len_r  <= len_sat;
      cur_byte_r <= in_payload_byte;
    end
    if (adv) begin
      out_byte_r      <= emit_byte;
      out_run_last_r  <= emit_last;
      out_frame_end_r <= (slot_r == SLOT_TAIL_SECOND);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_run_last_r;
  assign out_frame_end = out_frame_end_r;

  `ASSERT_SAME(a_end_is_last, out_valid_r && out_frame_end_r, out_run_last_r)
  `ASSERT_SAME(a_idle_takes_input, !cur_valid_r, !in_stall)
  `ASSERT_NEXT(a_tail_closes_frame, adv && (slot_r == SLOT_TAIL_SECOND), !open_r)
  `ASSERT_NEXT(a_seq_never_zero, adv && (slot_r == SLOT_HEAD_FIRST), seq_r != 16'h0000)

endmodule
